FILE: sv/bmb_pkg.sv
// Shared types, widths and helper functions for the blocked membership bitset.
// Used by the controller, the datapath and the top level; depends on nothing.
package bmb_pkg;

    localparam int CMD_W   = 3;
    localparam int ENT_W   = 16;
    localparam int BIDX_W  = 10;
    localparam int WORD_W  = 64;
    localparam int COUNT_W = 17;
    localparam int POP_W   = 7;

    localparam int DEF_BLOCK_BITS = 64;
    localparam int DEF_NUM_BLOCKS = 1024;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_EXISTS = 3'd2,
        CMD_CLEAR  = 3'd3,
        CMD_AND    = 3'd4,
        CMD_OR     = 3'd5,
        CMD_DIFF   = 3'd6,
        CMD_READ   = 3'd7
    } command_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic locate;
        logic modify;
        logic walk_init;
        logic walk_clear;
        logic commit;
    } bmb_ctrl_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic is_clear;
        logic init_last;
        logic clear_done;
    } bmb_stat_t;

    // Parallel bit count; every byte lane stays below 256, so no carries cross lanes.
    function automatic logic [POP_W-1:0] popcount64(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
        logic [WORD_W-1:0] d;
        logic [WORD_W-1:0] e;
        logic [WORD_W-1:0] f;
        a = x - ((x >> 1) & 64'h5555_5555_5555_5555);
        b = (a & 64'h3333_3333_3333_3333) + ((a >> 2) & 64'h3333_3333_3333_3333);
        c = (b + (b >> 4)) & 64'h0F0F_0F0F_0F0F_0F0F;
        d = c + (c >> 8);
        e = d + (d >> 16);
        f = e + (e >> 32);
        return f[POP_W-1:0];
    endfunction

endpackage

FILE: sv/bmb_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module bmb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/bmb_ctrl.sv
// Controller state machine for the blocked membership bitset.
// Depends on bmb_pkg; drives the datapath through bmb_ctrl_t and reads bmb_stat_t.
module bmb_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output bmb_pkg::bmb_ctrl_t ctrl,
    input  bmb_pkg::bmb_stat_t stat
);
    import bmb_pkg::*;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_LOCATE,
        S_MODIFY,
        S_CLEAR,
        S_COUNT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   commit;

    // The result register may be reloaded once it is empty or being drained.
    assign commit = (state_reg == S_COUNT) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_INIT: begin
                if (stat.init_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_LOCATE;
                end
            end
            S_LOCATE: begin
                state_next = stat.is_clear ? S_CLEAR : S_MODIFY;
            end
            S_MODIFY: begin
                state_next = S_COUNT;
            end
            S_CLEAR: begin
                if (stat.clear_done) begin
                    state_next = S_COUNT;
                end
            end
            S_COUNT: begin
                if (commit) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_INIT;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        ctrl            = '0;
        ctrl.load       = (state_reg == S_IDLE) && s_valid;
        ctrl.locate     = (state_reg == S_LOCATE);
        ctrl.modify     = (state_reg == S_MODIFY);
        ctrl.walk_init  = (state_reg == S_INIT);
        ctrl.walk_clear = (state_reg == S_CLEAR);
        ctrl.commit     = commit;
    end

endmodule

FILE: sv/bmb_datapath.sv
// Datapath of the blocked membership bitset: block address split, block store,
// read-modify-write of one block, population count and the result register.
// Depends on bmb_pkg and bmb_ram.
module bmb_datapath #(
    parameter int BLOCK_BITS = bmb_pkg::DEF_BLOCK_BITS,
    parameter int NUM_BLOCKS = bmb_pkg::DEF_NUM_BLOCKS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bmb_pkg::bmb_ctrl_t            ctrl,
    output bmb_pkg::bmb_stat_t            stat,
    input  logic [bmb_pkg::CMD_W-1:0]     s_command,
    input  logic [bmb_pkg::ENT_W-1:0]     s_entity_id,
    input  logic [bmb_pkg::BIDX_W-1:0]    s_block_index,
    input  logic [bmb_pkg::WORD_W-1:0]    s_block_bits,
    output logic                          m_was_present,
    output logic [bmb_pkg::COUNT_W-1:0]   m_member_count,
    output logic                          m_block_allocated,
    output logic [bmb_pkg::WORD_W-1:0]    m_block_word
);
    import bmb_pkg::*;

    localparam int AW        = $clog2(NUM_BLOCKS);
    localparam int BPW       = $clog2(BLOCK_BITS);
    localparam int RAM_W     = BLOCK_BITS + 1;
    localparam int DIV_SHIFT = 22;
    localparam int PROD_W    = ENT_W + DIV_SHIFT;
    // Floor reciprocal: the estimated quotient is exact or one too small.
    localparam logic [DIV_SHIFT-1:0] RECIP     = DIV_SHIFT'((1 << DIV_SHIFT) / BLOCK_BITS);
    localparam logic [ENT_W-1:0]     BB        = ENT_W'(BLOCK_BITS);
    localparam logic [ENT_W:0]       BLK_LIMIT = (ENT_W+1)'(NUM_BLOCKS);
    localparam logic [AW:0]          WALK_END  = (AW+1)'(NUM_BLOCKS);
    localparam logic [AW:0]          WALK_LAST = (AW+1)'(NUM_BLOCKS - 1);

    // Captured command.
    command_t              cmd_reg;
    logic [ENT_W-1:0]      ent_reg;
    logic [BIDX_W-1:0]     bidx_reg;
    logic [BLOCK_BITS-1:0] opnd_reg;
    logic [ENT_W-1:0]      qest_reg;
    // Located block.
    logic [ENT_W-1:0]      blk_reg;
    logic [BPW-1:0]        bitpos_reg;
    logic                  inrange_reg;
    // Modified block.
    logic [BLOCK_BITS-1:0] new_word_reg;
    logic                  new_valid_reg;
    logic                  present_reg;
    logic [POP_W-1:0]      pop_old_reg;
    // Control state.
    logic [COUNT_W-1:0]    population_reg;
    logic [COUNT_W-1:0]    population_next;
    logic [AW:0]           walk_reg;
    logic [AW:0]           walk_next;
    // Result register.
    logic                  was_present_reg;
    logic [COUNT_W-1:0]    member_count_reg;
    logic                  block_allocated_reg;
    logic [WORD_W-1:0]     block_word_reg;

    logic [PROD_W-1:0]     prod;
    logic [ENT_W-1:0]      qb;
    logic [ENT_W-1:0]      rem;
    logic                  fix;
    logic [ENT_W-1:0]      q_fix;
    logic [ENT_W-1:0]      r_fix;
    logic                  is_blk_cmd;
    logic [ENT_W-1:0]      blk_sel;
    logic                  inrange_sel;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [RAM_W-1:0]      ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [RAM_W-1:0]      ram_rdata;
    logic [AW:0]           walk_m1;

    logic                  rd_valid;
    logic                  old_valid;
    logic [BLOCK_BITS-1:0] old_word;
    logic [BLOCK_BITS-1:0] bitmask;
    logic [BLOCK_BITS-1:0] mod_word;
    logic                  mod_we;
    logic                  alloc;
    logic [POP_W-1:0]      pop_new;

    // Quotient estimate of entity_id / BLOCK_BITS, taken at the accepted beat.
    assign prod = PROD_W'(s_entity_id) * PROD_W'(RECIP);

    // One correction step gives the exact block number and bit position.
    assign qb         = ENT_W'(qest_reg * BB);
    assign rem        = ent_reg - qb;
    assign fix        = (rem >= BB);
    assign q_fix      = qest_reg + ENT_W'(fix);
    assign r_fix      = fix ? (rem - BB) : rem;
    assign is_blk_cmd = (cmd_reg == CMD_AND) || (cmd_reg == CMD_OR) || (cmd_reg == CMD_DIFF);
    assign blk_sel    = is_blk_cmd ? ENT_W'(bidx_reg) : q_fix;
    assign inrange_sel = ({1'b0, blk_sel} < BLK_LIMIT);

    // Stored word layout: valid flag on top of the block bits.
    assign rd_valid  = ram_rdata[BLOCK_BITS];
    assign old_valid = inrange_reg && rd_valid;
    assign old_word  = old_valid ? ram_rdata[BLOCK_BITS-1:0] : '0;
    assign bitmask   = BLOCK_BITS'(1) << bitpos_reg;

    always_comb begin
        mod_word = old_word;
        mod_we   = 1'b0;
        alloc    = 1'b0;
        case (cmd_reg)
            CMD_ADD: begin
                mod_word = old_word | bitmask;
                mod_we   = inrange_reg;
                alloc    = inrange_reg;
            end
            CMD_REMOVE: begin
                mod_word = old_word & ~bitmask;
                mod_we   = old_valid;
            end
            CMD_AND: begin
                mod_word = old_word & opnd_reg;
                mod_we   = old_valid;
            end
            CMD_OR: begin
                mod_word = old_word | opnd_reg;
                mod_we   = inrange_reg;
                alloc    = inrange_reg;
            end
            CMD_DIFF: begin
                mod_word = old_word & ~opnd_reg;
                mod_we   = old_valid;
            end
            default: begin
                mod_word = old_word;
            end
        endcase
    end

    assign walk_m1 = walk_reg - (AW+1)'(1);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = blk_reg[AW-1:0];
        ram_wdata = {1'b1, mod_word};
        if (ctrl.walk_init) begin
            ram_we    = 1'b1;
            ram_waddr = walk_reg[AW-1:0];
            ram_wdata = '0;
        end else if (ctrl.walk_clear) begin
            // The entry read in the previous cycle is written back empty, flag kept.
            ram_we    = (walk_reg != '0);
            ram_waddr = walk_m1[AW-1:0];
            ram_wdata = {rd_valid, {BLOCK_BITS{1'b0}}};
        end else if (ctrl.modify) begin
            ram_we = mod_we;
        end
    end

    assign ram_raddr = ctrl.walk_clear ? walk_reg[AW-1:0] : blk_sel[AW-1:0];

    bmb_ram #(
        .WIDTH(RAM_W),
        .DEPTH(NUM_BLOCKS)
    ) u_store (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign pop_new = popcount64(WORD_W'(new_word_reg));

    always_comb begin
        population_next = population_reg - COUNT_W'(pop_old_reg) + COUNT_W'(pop_new);
        if (cmd_reg == CMD_CLEAR) begin
            population_next = '0;
        end
    end

    always_comb begin
        walk_next = walk_reg;
        if (ctrl.walk_init) begin
            walk_next = (walk_reg == WALK_LAST) ? '0 : walk_reg + (AW+1)'(1);
        end else if (ctrl.walk_clear) begin
            walk_next = (walk_reg == WALK_END) ? '0 : walk_reg + (AW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            walk_reg       <= '0;
            population_reg <= '0;
        end else begin
            walk_reg <= walk_next;
            if (ctrl.commit) begin
                population_reg <= population_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            cmd_reg  <= command_t'(s_command);
            ent_reg  <= s_entity_id;
            bidx_reg <= s_block_index;
            opnd_reg <= s_block_bits[BLOCK_BITS-1:0];
            qest_reg <= prod[DIV_SHIFT +: ENT_W];
        end
        if (ctrl.locate) begin
            blk_reg     <= blk_sel;
            bitpos_reg  <= r_fix[BPW-1:0];
            inrange_reg <= inrange_sel;
        end
        if (ctrl.modify) begin
            new_word_reg  <= mod_word;
            new_valid_reg <= old_valid || alloc;
            present_reg   <= old_valid && (cmd_reg == CMD_ADD || cmd_reg == CMD_REMOVE ||
                             cmd_reg == CMD_EXISTS) && ((old_word & bitmask) != '0);
            pop_old_reg   <= popcount64(WORD_W'(old_word));
        end
        if (ctrl.commit) begin
            member_count_reg <= population_next;
            if (cmd_reg == CMD_CLEAR) begin
                was_present_reg     <= 1'b0;
                block_allocated_reg <= 1'b0;
                block_word_reg      <= '0;
            end else begin
                was_present_reg     <= present_reg;
                block_allocated_reg <= new_valid_reg;
                block_word_reg      <= new_valid_reg ? WORD_W'(new_word_reg) : '0;
            end
        end
    end

    always_comb begin
        stat            = '0;
        stat.is_clear   = (cmd_reg == CMD_CLEAR);
        stat.init_last  = (walk_reg == WALK_LAST);
        stat.clear_done = (walk_reg == WALK_END);
    end

    assign m_was_present     = was_present_reg;
    assign m_member_count    = member_count_reg;
    assign m_block_allocated = block_allocated_reg;
    assign m_block_word      = block_word_reg;

endmodule

FILE: sv/blocked_membership_bitset.sv
// Blocked membership bitset: a lazily allocated set of entity ids with a member count.
// Top level; depends on bmb_pkg, bmb_ctrl and bmb_datapath.
//
// Usage: one command beat enters on the s_ channel (command, entity_id,
// block_index, block_bits) and exactly one result beat leaves on the m_
// channel (was_present, member_count, block_allocated, block_word).
// Commands are handled one at a time. An ordinary command passes through
// the block address split, the read of the block store, the write back,
// and the count update that loads the result register; the next command
// is accepted only after that. Clear walks the whole block store one entry
// a cycle; the store has a single write port.
// After reset s_ready stays low while every entry of the store is marked
// unallocated; the count starts at zero.
// A result waits in its register while m_ready is low; the next command is
// still accepted and processed up to the count update, which holds until
// the waiting result has been taken.
module blocked_membership_bitset #(
    parameter int BLOCK_BITS = bmb_pkg::DEF_BLOCK_BITS,
    parameter int NUM_BLOCKS = bmb_pkg::DEF_NUM_BLOCKS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [bmb_pkg::CMD_W-1:0]   s_command,
    input  logic [bmb_pkg::ENT_W-1:0]   s_entity_id,
    input  logic [bmb_pkg::BIDX_W-1:0]  s_block_index,
    input  logic [bmb_pkg::WORD_W-1:0]  s_block_bits,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_was_present,
    output logic [bmb_pkg::COUNT_W-1:0] m_member_count,
    output logic                        m_block_allocated,
    output logic [bmb_pkg::WORD_W-1:0]  m_block_word
);
    import bmb_pkg::*;

    localparam int CAPACITY = NUM_BLOCKS * BLOCK_BITS;

    bmb_ctrl_t ctrl;
    bmb_stat_t stat;

    bmb_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .ctrl   (ctrl),
        .stat   (stat)
    );

    bmb_datapath #(
        .BLOCK_BITS(BLOCK_BITS),
        .NUM_BLOCKS(NUM_BLOCKS)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .ctrl             (ctrl),
        .stat             (stat),
        .s_command        (s_command),
        .s_entity_id      (s_entity_id),
        .s_block_index    (s_block_index),
        .s_block_bits     (s_block_bits),
        .m_was_present    (m_was_present),
        .m_member_count   (m_member_count),
        .m_block_allocated(m_block_allocated),
        .m_block_word     (m_block_word)
    );

    // Only one command is in flight, so acceptance closes the input side.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a command is in flight");

    // An unallocated block always reads back as an empty word.
    a_unalloc_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_block_allocated) |-> (m_block_word == '0))
        else $error("unallocated block returned a nonzero word");

    // The count never exceeds the number of bits the table can hold.
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (32'(m_member_count) <= CAPACITY))
        else $error("member count exceeds table capacity");

    // The controller never starts a store walk and a block update together.
    a_ctrl_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({ctrl.load, ctrl.locate, ctrl.modify, ctrl.walk_init, ctrl.walk_clear}))
        else $error("conflicting datapath commands");

endmodule
